### rtl/rpfv_pkg.sv
`timescale 1ns / 1ps

package rpfv_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;

  localparam int COORD_W    = 24;
  localparam int RADIUS_W   = 23;
  localparam int SIDES_W    = 6;
  localparam int IDX_W      = 6;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 23;

  // binary angle, one turn is 2^ANG_W
  localparam int ANG_W      = 32;
  // cordic datapath in Q2.30 with headroom
  localparam int CORD_W     = 34;
  localparam int TRIG_W     = 32;
  localparam int ATAN_LEN   = 24;
  localparam int ATAN_IDX_W = 5;
  localparam int GAIN_Q30   = 652032874;

  localparam logic [RADIUS_W-1:0]  RADIUS_RESET = RADIUS_W'(1 << FRAC_BITS);
  localparam logic [SIDES_W-1:0]   SIDES_RESET  = SIDES_W'(3);
  localparam logic [SIDES_W-1:0]   SIDES_MIN    = SIDES_W'(3);
  localparam logic [SIDES_W-1:0]   SIDES_MAX    = SIDES_W'(MAX_VERTICES - 2);

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SIDES  = CFG_IDX_W'(1);

  typedef struct packed {
    logic                     done;
    logic [ANG_W-1:0]         quo;
    logic [SIDES_W-1:0]       rem;
  } div_res_t;

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } cordic_res_t;

  // atan(2^-k) in units of 2^-32 turn
  function automatic logic [ANG_W-1:0] atan_val(input logic [ATAN_IDX_W-1:0] k);
    logic [ANG_W-1:0] v;
    case (k)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10680862;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/rpfv_req_if.sv
`timescale 1ns / 1ps

interface rpfv_req_if;
  import rpfv_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] center_z;

  modport source (output valid, center_x, center_y, center_z, input ready);
  modport sink   (input valid, center_x, center_y, center_z, output ready);
endinterface

### rtl/rpfv_vtx_if.sv
`timescale 1ns / 1ps

interface rpfv_vtx_if;
  import rpfv_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic signed [COORD_W-1:0] vertex_z;
  logic [IDX_W-1:0]          vertex_index;
  logic                      clipped;
  logic                      last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, vertex_index, clipped,
                  last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, vertex_index, clipped,
                  last_vertex, output ready);
endinterface

### rtl/rpfv_cfg_if.sv
`timescale 1ns / 1ps

interface rpfv_cfg_if;
  import rpfv_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/rpfv_div.sv
`timescale 1ns / 1ps

// restoring divider: floor(2^ANG_W / n) and 2^ANG_W mod n, one quotient bit a cycle
module rpfv_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rpfv_pkg::SIDES_W-1:0]  n,
  output rpfv_pkg::div_res_t            res
);
  import rpfv_pkg::*;

  localparam int DIV_STEPS = ANG_W + 1;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t              state;
  logic [CNT_W-1:0]     cnt;
  logic [SIDES_W-1:0]   dvs;
  logic [SIDES_W-1:0]   rem;
  logic [ANG_W-1:0]     quo;
  logic [SIDES_W:0]     trial;
  logic                 fits;
  logic                 done;

  // dividend is a one followed by ANG_W zeros
  assign trial = {rem, (cnt == '0)};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == D_RUN) && (cnt == CNT_W'(DIV_STEPS - 1));
      case (state)
        D_IDLE: begin
          if (start) begin
            dvs   <= n;
            rem   <= '0;
            quo   <= '0;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= fits ? SIDES_W'(trial - {1'b0, dvs}) : trial[SIDES_W-1:0];
          quo <= {quo[ANG_W-2:0], fits};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_STEPS - 1))
            state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  assign res.done = done;
  assign res.quo  = quo;
  assign res.rem  = rem;

endmodule

### rtl/rpfv_cordic.sv
`timescale 1ns / 1ps

// rotation-mode cordic, one micro-rotation a cycle, quadrant fold at the end
module rpfv_cordic (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rpfv_pkg::ANG_W-1:0]  angle,
  output rpfv_pkg::cordic_res_t       res
);
  import rpfv_pkg::*;

  localparam logic signed [CORD_W-1:0] GAIN_INIT = CORD_W'(GAIN_Q30);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_MAP} cstate_t;

  cstate_t                 state;
  logic signed [CORD_W-1:0] x, y, z;
  logic signed [CORD_W-1:0] dx, dy, at;
  logic signed [CORD_W-1:0] x_next, y_next, z_next;
  logic signed [CORD_W-1:0] c_map, s_map;
  logic [1:0]               quad;
  logic [ATAN_IDX_W-1:0]    k;

  always_comb begin
    dx = y >>> k;
    dy = x >>> k;
    at = signed'(CORD_W'(atan_val(k)));
    if (!z[CORD_W-1]) begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - at;
    end else begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + at;
    end
  end

  always_comb begin
    case (quad)
      2'd0: begin c_map = x;  s_map = y;  end
      2'd1: begin c_map = -y; s_map = x;  end
      2'd2: begin c_map = -x; s_map = -y; end
      default: begin c_map = y; s_map = -x; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= C_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= (state == C_MAP);
      case (state)
        C_IDLE: begin
          if (start) begin
            x     <= GAIN_INIT;
            y     <= '0;
            z     <= signed'(CORD_W'(angle[ANG_W-3:0]));
            quad  <= angle[ANG_W-1:ANG_W-2];
            k     <= '0;
            state <= C_RUN;
          end
        end
        C_RUN: begin
          x <= x_next;
          y <= y_next;
          z <= z_next;
          k <= k + 1'b1;
          if (k == ATAN_IDX_W'(CORDIC_STEPS - 1))
            state <= C_MAP;
        end
        C_MAP: begin
          res.cos_v <= c_map[TRIG_W-1:0];
          res.sin_v <= s_map[TRIG_W-1:0];
          state     <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

### rtl/regular_polygon_fan_vertices_core.sv
`timescale 1ns / 1ps

// channel  dir  payload                                                  handshake
// req      in   center_x, center_y, center_z                             valid/ready
// vtx      out  vertex_x, vertex_y, vertex_z, vertex_index, clipped,     valid/ready
//               last_vertex
// cfg      in   index, data (0 radius, 1 side_count)                     valid/ready
//
// a request runs the 33-step angle divider once, then the per-vertex cordic loop
// for each of the N + 1 vertices that follow the center
// req.ready is high only between requests; cfg.ready is always high
// rst is synchronous and restores radius 1.0 and three sides, no clearing pass
// a stalled vtx holds the engine only when the next vertex is ready to be loaded
module regular_polygon_fan_vertices_core (
  input  logic        clk,
  input  logic        rst,
  rpfv_req_if.sink    req,
  rpfv_vtx_if.source  vtx,
  rpfv_cfg_if.sink    cfg
);
  import rpfv_pkg::*;

  localparam int PROD_W = RADIUS_W + 1 + TRIG_W;
  localparam int OFF_W  = PROD_W - 30;
  localparam int SUM_W  = OFF_W + 1;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << 29);
  localparam logic signed [SUM_W-1:0]  SUM_MAX    = SUM_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0]  SUM_MIN    = -SUM_W'(1 << (COORD_W - 1));

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_CENTER, S_ROT, S_MULC, S_MULS, S_EMIT
  } state_t;

  state_t                    state;
  logic [RADIUS_W-1:0]       radius;
  logic [SIDES_W-1:0]        side_count;
  logic signed [COORD_W-1:0] cx, cy, cz;
  logic [SIDES_W-1:0]        n_eff, n_clamp;
  logic [IDX_W-1:0]          vidx;
  logic [ANG_W-1:0]          q_acc, qstep;
  logic [SIDES_W-1:0]        r_acc, rstep;
  logic [SIDES_W:0]          r_sum;
  logic                      r_wrap;
  logic signed [PROD_W-1:0]  prod, mul_p;
  logic signed [TRIG_W-1:0]  mul_b;
  logic signed [RADIUS_W:0]  radius_s;
  logic signed [COORD_W-1:0] sat_c;
  logic [COORD_W:0]          sat_o;
  logic signed [COORD_W-1:0] vx;
  logic                      clip_x;
  logic                      out_free;
  logic                      emit_vtx;
  logic                      fan_end;
  logic                      div_start, cor_start;
  div_res_t                  div_res;
  cordic_res_t               cor_res;

  function automatic logic [COORD_W:0] sat_add(input logic signed [COORD_W-1:0] c,
                                               input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] rp;
    logic signed [OFF_W-1:0]  off;
    logic signed [SUM_W-1:0]  sum;
    rp  = p + ROUND_HALF;
    off = rp[PROD_W-1:30];
    sum = SUM_W'(c) + SUM_W'(off);
    if (sum > SUM_MAX)
      return {1'b1, SUM_MAX[COORD_W-1:0]};
    else if (sum < SUM_MIN)
      return {1'b1, SUM_MIN[COORD_W-1:0]};
    else
      return {1'b0, sum[COORD_W-1:0]};
  endfunction

  rpfv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n     (n_eff),
    .res   (div_res)
  );

  rpfv_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (q_acc),
    .res   (cor_res)
  );

  always_comb begin
    if (side_count < SIDES_MIN)
      n_clamp = SIDES_MIN;
    else if (side_count > SIDES_MAX)
      n_clamp = SIDES_MAX;
    else
      n_clamp = side_count;
  end

  assign out_free = !vtx.valid || vtx.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  // a vertex goes out this cycle, and whether it closes the fan
  assign emit_vtx = out_free && ((state == S_CENTER) || (state == S_EMIT));
  assign fan_end  = (vidx == IDX_W'(n_eff) + IDX_W'(1));

  // one multiplier and one saturating adder, shared between x and y
  assign radius_s = signed'({1'b0, radius});
  assign mul_b    = (state == S_MULC) ? cor_res.cos_v : cor_res.sin_v;
  assign mul_p    = radius_s * mul_b;
  assign sat_c    = (state == S_MULS) ? cx : cy;
  assign sat_o    = sat_add(sat_c, prod);

  // angle of the next vertex: add floor(2^32/N) and carry the remainder
  assign r_sum  = {1'b0, r_acc} + {1'b0, rstep};
  assign r_wrap = r_sum >= {1'b0, n_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      radius     <= RADIUS_RESET;
      side_count <= SIDES_RESET;
      vtx.valid  <= 1'b0;
      div_start  <= 1'b0;
      cor_start  <= 1'b0;
    end else begin
      div_start <= (state == S_IDLE) && req.valid;
      cor_start <= emit_vtx && !((state == S_EMIT) && fan_end);
      if (emit_vtx)
        vtx.valid <= 1'b1;
      else if (vtx.valid && vtx.ready)
        vtx.valid <= 1'b0;

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_RADIUS: radius     <= cfg.data[RADIUS_W-1:0];
          REG_SIDES:  side_count <= cfg.data[SIDES_W-1:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cx        <= req.center_x;
            cy        <= req.center_y;
            cz        <= req.center_z;
            n_eff     <= n_clamp;
            vidx      <= IDX_W'(1);
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            qstep <= div_res.quo;
            rstep <= div_res.rem;
            q_acc <= div_res.quo;
            r_acc <= div_res.rem;
            state <= S_CENTER;
          end
        end
        S_CENTER: begin
          if (out_free) begin
            vtx.vertex_x     <= cx;
            vtx.vertex_y     <= cy;
            vtx.vertex_z     <= cz;
            vtx.vertex_index <= '0;
            vtx.clipped      <= 1'b0;
            vtx.last_vertex  <= 1'b0;
            state            <= S_ROT;
          end
        end
        S_ROT: begin
          if (cor_res.done)
            state <= S_MULC;
        end
        S_MULC: begin
          prod  <= mul_p;
          state <= S_MULS;
        end
        S_MULS: begin
          vx     <= sat_o[COORD_W-1:0];
          clip_x <= sat_o[COORD_W];
          prod   <= mul_p;
          state  <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            vtx.vertex_x     <= vx;
            vtx.vertex_y     <= sat_o[COORD_W-1:0];
            vtx.vertex_z     <= cz;
            vtx.vertex_index <= vidx;
            vtx.clipped      <= clip_x | sat_o[COORD_W];
            vtx.last_vertex  <= fan_end;
            if (fan_end) begin
              state <= S_IDLE;
            end else begin
              vidx      <= vidx + 1'b1;
              q_acc     <= q_acc + qstep + ANG_W'(r_wrap);
              r_acc     <= r_wrap ? SIDES_W'(r_sum - {1'b0, n_eff}) : r_sum[SIDES_W-1:0];
              state     <= S_ROT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/rpfv_checker.sv
`timescale 1ns / 1ps

module rpfv_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic                               vtx_valid,
  input logic                               vtx_ready,
  input logic signed [rpfv_pkg::COORD_W-1:0] vertex_x,
  input logic signed [rpfv_pkg::COORD_W-1:0] vertex_y,
  input logic signed [rpfv_pkg::COORD_W-1:0] vertex_z,
  input logic [rpfv_pkg::IDX_W-1:0]         vertex_index,
  input logic                               clipped,
  input logic                               last_vertex
);
  import rpfv_pkg::*;

  // a stalled vertex stays put
  a_vtx_hold: assert property (@(posedge clk) disable iff (rst)
    vtx_valid && !vtx_ready |=> vtx_valid && $stable(vertex_x) && $stable(vertex_y)
      && $stable(vertex_z) && $stable(vertex_index) && $stable(clipped)
      && $stable(last_vertex))
    else $error("vertex changed while stalled");

  // a fan in progress blocks new requests
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while a fan is in progress");

  // the center carries no clip and never ends the fan
  a_center_flags: assert property (@(posedge clk) disable iff (rst)
    vtx_valid && (vertex_index == '0) |-> !clipped && !last_vertex)
    else $error("center vertex flagged");

  // the shortest fan is a triangle: center plus four vertices
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    vtx_valid && last_vertex |-> vertex_index >= IDX_W'(4))
    else $error("fan ended too early");

endmodule

bind regular_polygon_fan_vertices_core rpfv_checker u_rpfv_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .vtx_valid    (vtx.valid),
  .vtx_ready    (vtx.ready),
  .vertex_x     (vtx.vertex_x),
  .vertex_y     (vtx.vertex_y),
  .vertex_z     (vtx.vertex_z),
  .vertex_index (vtx.vertex_index),
  .clipped      (vtx.clipped),
  .last_vertex  (vtx.last_vertex)
);

### bench/rpfv_fan_checker.sv
`timescale 1ns / 1ps

module rpfv_fan_checker
  import rpfv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rpfv_req_if         req,
  rpfv_vtx_if         vtx,
  rpfv_cfg_if         cfg,
  output int unsigned fail_count,
  output int unsigned outstanding
);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [IDX_W-1:0]          idx;
    logic                      clipped;
    logic                      last;
  } vertex_t;

  localparam longint COORD_HI  = (64'sd1 <<< (COORD_W - 1)) - 1;
  localparam longint COORD_LO  = -(64'sd1 <<< (COORD_W - 1));
  localparam int     TRIG_FRAC = 30;
  localparam longint HALF_LSB  = 64'sd1 <<< (TRIG_FRAC - 1);

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;

  // atan(2^-k) as a fraction of a full turn, 2^32 per turn
  localparam longint ARCTAN [ATAN_LEN] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  logic [RADIUS_W-1:0] radius_q;
  logic [SIDES_W-1:0]  sides_q;
  vertex_t             fan_due [$];

  // cos and sin in Q2.30 for a binary angle
  function automatic void unit_vector(input logic [ANG_W-1:0] angle,
                                      output longint c, output longint s);
    longint x, y, z, dx, dy;
    int     k;
    x = GAIN_Q30;
    y = 0;
    z = longint'(angle[ANG_W-3:0]);
    for (k = 0; k < CORDIC_STEPS && k < ATAN_LEN; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ARCTAN[k];
      end else begin
        x += dx;
        y -= dy;
        z += ARCTAN[k];
      end
    end
    case (angle[ANG_W-1 -: 2])
      QUAD_I: begin
        c = x;
        s = y;
      end
      QUAD_II: begin
        c = -y;
        s = x;
      end
      QUAD_III: begin
        c = -x;
        s = -y;
      end
      default: begin
        c = y;
        s = -x;
      end
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] offset_coord(input longint center,
                                                             input longint trig,
                                                             input logic [RADIUS_W-1:0] r,
                                                             output logic hit);
    longint sum;
    sum = center + ((longint'(r) * trig + HALF_LSB) >>> TRIG_FRAC);
    hit = 1'b0;
    if (sum > COORD_HI) begin
      hit = 1'b1;
      sum = COORD_HI;
    end else if (sum < COORD_LO) begin
      hit = 1'b1;
      sum = COORD_LO;
    end
    return sum[COORD_W-1:0];
  endfunction

  function automatic void predict_fan(input logic signed [COORD_W-1:0] cx,
                                      input logic signed [COORD_W-1:0] cy,
                                      input logic signed [COORD_W-1:0] cz);
    vertex_t          v;
    int               n, i;
    longint           c, s;
    logic [ANG_W-1:0] angle;
    logic             hit_x, hit_y;
    n = int'(sides_q);
    if (n < int'(SIDES_MIN)) n = int'(SIDES_MIN);
    if (n > int'(SIDES_MAX)) n = int'(SIDES_MAX);
    v.x       = cx;
    v.y       = cy;
    v.z       = cz;
    v.idx     = '0;
    v.clipped = 1'b0;
    v.last    = 1'b0;
    fan_due.push_back(v);
    // last vertex repeats the angle of vertex one and closes the fan
    for (i = 1; i <= n + 1; i++) begin
      angle = ANG_W'((longint'(i % n) << ANG_W) / n);
      unit_vector(angle, c, s);
      v.x       = offset_coord(longint'(cx), c, radius_q, hit_x);
      v.y       = offset_coord(longint'(cy), s, radius_q, hit_y);
      v.z       = cz;
      v.idx     = IDX_W'(i);
      v.clipped = hit_x | hit_y;
      v.last    = (i == n + 1);
      fan_due.push_back(v);
    end
  endfunction

  always @(posedge clk) begin
    vertex_t want;
    if (rst) begin
      radius_q = RADIUS_RESET;
      sides_q  = SIDES_RESET;
      fan_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_RADIUS: radius_q = cfg.data[RADIUS_W-1:0];
          REG_SIDES:  sides_q  = cfg.data[SIDES_W-1:0];
          default:    ;
        endcase
      end
      if (req.valid && req.ready) predict_fan(req.center_x, req.center_y, req.center_z);
      if (vtx.valid && vtx.ready) begin
        if (fan_due.size() == 0) begin
          $error("vertex %0d with no request outstanding", vtx.vertex_index);
          fail_count++;
        end else begin
          want = fan_due.pop_front();
          if (vtx.vertex_x !== want.x) begin
            $error("vertex_x: expected %0d, got %0d", want.x, vtx.vertex_x);
            fail_count++;
          end
          if (vtx.vertex_y !== want.y) begin
            $error("vertex_y: expected %0d, got %0d", want.y, vtx.vertex_y);
            fail_count++;
          end
          if (vtx.vertex_z !== want.z) begin
            $error("vertex_z: expected %0d, got %0d", want.z, vtx.vertex_z);
            fail_count++;
          end
          if (vtx.vertex_index !== want.idx) begin
            $error("vertex_index: expected %0d, got %0d", want.idx, vtx.vertex_index);
            fail_count++;
          end
          if (vtx.clipped !== want.clipped) begin
            $error("clipped: expected %0b, got %0b", want.clipped, vtx.clipped);
            fail_count++;
          end
          if (vtx.last_vertex !== want.last) begin
            $error("last_vertex: expected %0b, got %0b", want.last, vtx.last_vertex);
            fail_count++;
          end
        end
      end
    end
    outstanding = fan_due.size();
  end

endmodule

### bench/tb_regular_polygon_fan_vertices_core.sv
`timescale 1ns / 1ps

module tb_regular_polygon_fan_vertices_core;
  import rpfv_pkg::*;

  localparam int QUIET_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 1400;
  localparam int PHASES       = 35;
  localparam int PHASE_ITEMS  = 10;

  localparam logic signed [COORD_W-1:0] COORD_HI   = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_LO   = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [RADIUS_W-1:0]       RADIUS_TOP = '1;
  localparam logic [SIDES_W-1:0]        SIDES_TOP  = '1;

  logic        clk = 1'b0;
  logic        rst;
  bit          source_gaps = 1'b1;
  bit          sink_stalls = 1'b1;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned quiet;
  int unsigned stall_left;

  rpfv_req_if req_ch ();
  rpfv_vtx_if vtx_ch ();
  rpfv_cfg_if cfg_ch ();

  regular_polygon_fan_vertices_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .vtx (vtx_ch),
    .cfg (cfg_ch)
  );

  rpfv_fan_checker fan_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .vtx         (vtx_ch),
    .cfg         (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return COORD_HI;
      1:       return COORD_LO;
      // close to the rails so the fan clips
      2:       return COORD_W'(COORD_HI - $urandom_range(0, 1 << 20));
      3:       return COORD_W'(COORD_LO + $urandom_range(0, 1 << 20));
      4:       return COORD_W'($urandom_range(0, 1 << 18) - (1 << 17));
      default: return COORD_W'($urandom());
    endcase
  endfunction

  function automatic logic [RADIUS_W-1:0] pick_radius();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return RADIUS_TOP;
      2:       return RADIUS_W'($urandom_range(1, 255));
      3, 4, 5: return RADIUS_W'($urandom_range(1 << 14, 1 << 19));
      default: return RADIUS_W'($urandom());
    endcase
  endfunction

  // mostly small fans, large ones are slow
  function automatic logic [SIDES_W-1:0] pick_sides();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return SIDES_W'($urandom_range(SIDES_MIN, 8));
    if (pick < 85) return SIDES_W'($urandom_range(9, 30));
    if (pick < 93) return SIDES_W'($urandom_range(31, SIDES_TOP));
    return SIDES_W'($urandom_range(0, SIDES_MIN - 1));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic write_spare();
    write_reg(CFG_IDX_W'($urandom_range(REG_SIDES + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'($urandom()));
  endtask

  task automatic drain_fans();
    while (outstanding != 0) @(negedge clk);
  endtask

  // upper data bits of the side count write are junk and must be dropped
  task automatic set_shape(input logic [RADIUS_W-1:0] r, input logic [SIDES_W-1:0] n);
    logic [CFG_DATA_W-1:0] value;
    drain_fans();
    write_reg(REG_RADIUS, r);
    value = CFG_DATA_W'($urandom());
    value[SIDES_W-1:0] = n;
    write_reg(REG_SIDES, value);
  endtask

  task automatic send_center(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] z);
    int unsigned gap;
    req_ch.center_x = x;
    req_ch.center_y = y;
    req_ch.center_z = z;
    req_ch.valid    = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    req_ch.valid = 1'b0;
    gap = source_gaps ? gap_len() : 0;
    repeat (gap) @(negedge clk);
  endtask

  initial begin
    vtx_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        vtx_ch.ready = 1'b0;
        stall_left--;
      end else begin
        vtx_ch.ready = 1'b1;
        if (sink_stalls && $urandom_range(0, 2) == 0) stall_left = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (vtx_ch.valid && vtx_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int p, k;
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.center_x = '0;
    req_ch.center_y = '0;
    req_ch.center_z = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_RADIUS;
    cfg_ch.data     = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset shape: unit radius, triangle
    send_center('0, '0, '0);
    send_center(COORD_HI, COORD_HI, COORD_HI);
    send_center(COORD_LO, COORD_LO, COORD_LO);
    send_center(COORD_HI, COORD_LO, '0);
    send_center(-COORD_W'(1), COORD_W'(1), -COORD_W'(1));
    drain_fans();
    write_spare();
    send_center(COORD_W'(12345), -COORD_W'(54321), COORD_HI);

    // side count below three
    set_shape(RADIUS_TOP, '0);
    send_center('0, '0, '0);
    send_center(COORD_HI, COORD_LO, '0);
    send_center(COORD_LO, COORD_HI, COORD_HI);
    // side count above the fan limit
    set_shape(RADIUS_TOP, SIDES_TOP);
    send_center('0, '0, COORD_LO);
    send_center(COORD_HI, COORD_HI, '0);
    set_shape('0, SIDES_MAX);
    send_center(pick_coord(), pick_coord(), pick_coord());
    set_shape(RADIUS_RESET, SIDES_W'(1));
    send_center(COORD_LO, COORD_HI, '0);
    set_shape(RADIUS_RESET, SIDES_W'(2));
    send_center(pick_coord(), pick_coord(), pick_coord());
    set_shape(RADIUS_W'(1), SIDES_MIN);
    send_center(COORD_HI, COORD_LO, COORD_HI);

    for (p = 0; p < PHASES; p++) begin
      source_gaps = (p % 3 != 2);
      sink_stalls = (p % 4 != 3);
      set_shape(pick_radius(), pick_sides());
      if ($urandom_range(0, 3) == 0) write_spare();
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // hold the next request until every vertex is out
        if (p == PHASES / 2 && k == PHASE_ITEMS / 2) drain_fans();
        send_center(pick_coord(), pick_coord(), pick_coord());
      end
    end

    drain_fans();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/rpfv_pkg.sv
rtl/rpfv_req_if.sv
rtl/rpfv_vtx_if.sv
rtl/rpfv_cfg_if.sv
rtl/rpfv_div.sv
rtl/rpfv_cordic.sv
rtl/regular_polygon_fan_vertices_core.sv
rtl/rpfv_checker.sv
bench/rpfv_fan_checker.sv
bench/tb_regular_polygon_fan_vertices_core.sv
